// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl of the gaussian blur block
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gblur_pkg.sv =====
// constants and register codes of the 3x3 gaussian blur block
// no dependencies
`default_nettype none

package gblur_pkg;

  localparam int unsigned MaxWidthDef    = 2048;
  localparam int unsigned ChannelBitsDef = 16;
  localparam int unsigned MaxHeight      = 4096;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ImgWidthW  = 12;
  localparam int unsigned ImgHeightW = 13;
  localparam int unsigned WeightW    = 16;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CENTER = 3'd2,
    REG_AXIS   = 3'd3,
    REG_CORNER = 3'd4
  } cfg_reg_e;

  // reset values of the registers
  localparam logic [ImgWidthW-1:0]  WidthRst  = 12'd2048;
  localparam logic [ImgHeightW-1:0] HeightRst = 13'd1080;
  localparam logic [WeightW-1:0]    CenterRst = 16'd19736;
  localparam logic [WeightW-1:0]    AxisRst   = 16'd8114;
  localparam logic [WeightW-1:0]    CornerRst = 16'd3336;

  // rounding constant for the q0.16 weights
  localparam int unsigned RoundBit = 15;
  localparam int unsigned FracBits = 16;

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_3x3_rgba.sv =====
// 3x3 gaussian blur of rgba pixels with clamp-to-edge borders
// depends on gblur_pkg and assert_macros.svh
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata: red,green,blue,alpha; tuser: kind
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: red,green,blue,alpha; tlast: frame_done
// cfg      in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// one item per cycle when the output does not stall; an item at the last column of a
// line wider than one pixel yields two results and holds the input while the window
// shifts in the edge column; results pass the window, product and output registers
// line stores use one read and one write port, with a registered read ahead at the next column
// no clearing pass after reset: line stores are read only after being written
// a stalled output fills the product and window stages before ready drops
`default_nettype none

module gaussian_blur_3x3_rgba #(
  parameter int unsigned MAX_WIDTH    = gblur_pkg::MaxWidthDef,
  parameter int unsigned CHANNEL_BITS = gblur_pkg::ChannelBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // red, green, blue, alpha from the low bits, zero padded to bytes
  input  wire logic [((4*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  wire logic                        s_axis_tuser,
  // output stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // red, green, blue, alpha from the low bits, zero padded to bytes
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  // frame_done
  output logic                             m_axis_tlast,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [gblur_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [gblur_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned CB      = CHANNEL_BITS;
  localparam int unsigned TDATA_W = ((4*CB+7)/8)*8;
  localparam int unsigned COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW      = ($clog2(MAX_WIDTH + 1) > gblur_pkg::ImgWidthW) ?
                                    $clog2(MAX_WIDTH + 1) : gblur_pkg::ImgWidthW;
  localparam int unsigned HW      = gblur_pkg::ImgHeightW;
  localparam int unsigned PCW     = CB + gblur_pkg::WeightW;
  localparam int unsigned PSW     = CB + 2 + gblur_pkg::WeightW;
  localparam int unsigned SUMW    = CB + 4 + gblur_pkg::WeightW;
  localparam int unsigned VW      = SUMW - gblur_pkg::FracBits;

  typedef logic [3:0][CB-1:0] pix_t;

  // configuration registers
  logic [gblur_pkg::ImgWidthW-1:0]  width_q;
  logic [HW-1:0]                    height_q;
  logic [gblur_pkg::WeightW-1:0]    wc_q, wa_q, wk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gblur_pkg::WidthRst;
      height_q <= gblur_pkg::HeightRst;
      wc_q     <= gblur_pkg::CenterRst;
      wa_q     <= gblur_pkg::AxisRst;
      wk_q     <= gblur_pkg::CornerRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gblur_pkg::REG_WIDTH:  width_q  <= cfg_data_i[gblur_pkg::ImgWidthW-1:0];
        gblur_pkg::REG_HEIGHT: height_q <= cfg_data_i[HW-1:0];
        gblur_pkg::REG_CENTER: wc_q     <= cfg_data_i;
        gblur_pkg::REG_AXIS:   wa_q     <= cfg_data_i;
        gblur_pkg::REG_CORNER: wk_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0] width_ext, width_eff, last_col;
  logic [HW-1:0] height_eff;

  always_comb begin
    width_ext = WW'(width_q);
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    last_col = width_eff - WW'(1);
    if (height_q == '0) begin
      height_eff = HW'(1);
    end else if (height_q > HW'(gblur_pkg::MaxHeight)) begin
      height_eff = HW'(gblur_pkg::MaxHeight);
    end else begin
      height_eff = height_q;
    end
  end

  // position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [HW-1:0]    row_q, row_d;
  logic             drain_q, drain_d;

  // window control
  logic emit_q, extra_q, done_q, last_q;
  logic p_valid_q, p_done_q;
  logic out_valid_q, out_last_q;

  logic out_free, p_free, s1_free, fire;
  logic in_acc, acc_pix, acc_flush, acc_shift, end_line, col_nz;
  pix_t px;

  assign out_free = !out_valid_q || m_axis_tready;
  assign p_free   = !p_valid_q || out_free;
  assign fire     = emit_q && p_free;
  assign s1_free  = !emit_q || p_free;

  assign s_axis_tready = s1_free && !extra_q;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign acc_pix   = in_acc && !s_axis_tuser && !drain_q;
  assign acc_flush = in_acc && s_axis_tuser && drain_q;
  assign acc_shift = (acc_pix && (row_q != '0)) || acc_flush;
  assign end_line  = WW'(col_q) >= last_col;
  assign col_nz    = (col_q != '0);
  assign px        = pix_t'(s_axis_tdata[4*CB-1:0]);

  // counter next state
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (acc_pix) begin
      if (end_line) begin
        col_d = '0;
        row_d = row_q + HW'(1);
        if ((row_q + HW'(1)) >= height_eff) begin
          drain_d = 1'b1;
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (acc_flush) begin
      if (end_line) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  // line stores, with a registered read ahead at the next column
  pix_t up_mem [MAX_WIDTH];
  pix_t lo_mem [MAX_WIDTH];
  pix_t up_rd_q, lo_rd_q, up_byp_q, lo_byp_q;
  pix_t up_wdata, up_eff, lo_eff;
  logic byp_q;

  always_comb begin
    up_eff   = byp_q ? up_byp_q : up_rd_q;
    lo_eff   = byp_q ? lo_byp_q : lo_rd_q;
    up_wdata = (row_q == '0) ? px : lo_eff;
  end

  always_ff @(posedge clk_i) begin
    if (acc_pix) begin
      up_mem[col_q] <= up_wdata;
      lo_mem[col_q] <= px;
    end
    up_rd_q  <= up_mem[col_d];
    lo_rd_q  <= lo_mem[col_d];
    up_byp_q <= up_wdata;
    lo_byp_q <= px;
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= acc_pix && (col_q == col_d);
    end
  end

  // 3x3 window, [column left..right][row top..bottom]
  pix_t win_q [3][3];
  pix_t new_col [3];

  always_comb begin
    new_col[0] = up_eff;
    new_col[1] = lo_eff;
    new_col[2] = acc_flush ? lo_eff : px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (acc_shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[2][r] <= new_col[r];
        win_q[1][r] <= col_nz ? win_q[2][r] : new_col[r];
        win_q[0][r] <= col_nz ? win_q[1][r] : new_col[r];
      end
    end else if (fire && extra_q) begin
      // right edge: replicate the last column
      for (int r = 0; r < 3; r++) begin
        win_q[0][r] <= win_q[1][r];
        win_q[1][r] <= win_q[2][r];
      end
    end
  end

  // emit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q  <= 1'b0;
      extra_q <= 1'b0;
      done_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (acc_shift) begin
      emit_q  <= col_nz || end_line;
      extra_q <= col_nz && end_line;
      done_q  <= end_line && !col_nz && acc_flush;
      last_q  <= acc_flush;
    end else if (fire && extra_q) begin
      emit_q  <= 1'b1;
      extra_q <= 1'b0;
      done_q  <= last_q;
    end else if (fire) begin
      emit_q <= 1'b0;
    end
  end

  // product stage
  logic [3:0][PCW-1:0] pc_q;
  logic [3:0][PSW-1:0] pa_q, pk_q;
  logic [3:0][CB+1:0]  ax_sum, co_sum;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      ax_sum[ch] = (CB+2)'(win_q[0][1][ch]) + (CB+2)'(win_q[2][1][ch])
                 + (CB+2)'(win_q[1][0][ch]) + (CB+2)'(win_q[1][2][ch]);
      co_sum[ch] = (CB+2)'(win_q[0][0][ch]) + (CB+2)'(win_q[2][0][ch])
                 + (CB+2)'(win_q[0][2][ch]) + (CB+2)'(win_q[2][2][ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int ch = 0; ch < 4; ch++) begin
        pc_q[ch] <= PCW'(win_q[1][1][ch]) * PCW'(wc_q);
        pa_q[ch] <= PSW'(ax_sum[ch]) * PSW'(wa_q);
        pk_q[ch] <= PSW'(co_sum[ch]) * PSW'(wk_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_done_q  <= 1'b0;
    end else if (p_free) begin
      p_valid_q <= fire;
      p_done_q  <= done_q;
    end
  end

  // sum, round, saturate
  pix_t out_pix_q, out_pix_d;
  logic [SUMW-1:0] acc_sum;
  logic [VW-1:0]   acc_v;

  always_comb begin
    acc_sum   = '0;
    acc_v     = '0;
    out_pix_d = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc_sum = SUMW'(pc_q[ch]) + SUMW'(pa_q[ch]) + SUMW'(pk_q[ch])
              + (SUMW'(1) << gblur_pkg::RoundBit);
      acc_v   = acc_sum[SUMW-1:gblur_pkg::FracBits];
      if (acc_v > VW'({CB{1'b1}})) begin
        out_pix_d[ch] = {CB{1'b1}};
      end else begin
        out_pix_d[ch] = acc_v[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && p_valid_q) begin
      out_pix_q <= out_pix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= p_valid_q;
      out_last_q  <= p_done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_pix_q);
  assign m_axis_tlast  = out_last_q;

  // checks
  `include "assert_macros.svh"

  `ASSERT_IMPL(a_extra_needs_emit, extra_q, emit_q)
  `ASSERT_NEXT(a_edge_emit_follows, fire && extra_q, emit_q && !extra_q)
  `ASSERT_NEXT(a_frame_end_clears, acc_flush && end_line,
               !drain_q && (row_q == '0) && (col_q == '0))
  `ASSERT_IMPL(a_full_stall_blocks, emit_q && p_valid_q && out_valid_q && !m_axis_tready,
               !s_axis_tready)

endmodule

`default_nettype wire

// ===== verif/gblur_checker.sv =====
`timescale 1ns / 1ps
// result checker for the 3x3 gaussian blur: tracks register writes, predicts
// filtered pixels from the accepted items and compares them in order
// depends on gblur_pkg
module gblur_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream as seen by the block
  input  wire logic                           s_valid_i,
  input  wire logic                           s_ready_i,
  // red, green, blue, alpha from the low bits
  input  wire logic [63:0]                    s_data_i,
  // kind
  input  wire logic                           s_user_i,
  // output stream as seen by the block
  input  wire logic                           m_valid_i,
  input  wire logic                           m_ready_i,
  // red, green, blue, alpha from the low bits
  input  wire logic [63:0]                    m_data_i,
  input  wire logic                           m_last_i,
  // register writes
  input  wire logic                           cfg_we_i,
  input  wire logic [gblur_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [gblur_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         awaiting_o
);

  localparam int unsigned ChanW = gblur_pkg::ChannelBitsDef;
  localparam int unsigned PixW  = 4 * ChanW;
  localparam int unsigned ColW  = $clog2(gblur_pkg::MaxWidthDef);
  localparam logic [63:0] ChanMax = (64'd1 << ChanW) - 64'd1;
  localparam logic KindFlush = 1'b1;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            done;
  } blurred_t;

  // register copies
  logic [gblur_pkg::ImgWidthW-1:0]  width_reg;
  logic [gblur_pkg::ImgHeightW-1:0] height_reg;
  logic [gblur_pkg::WeightW-1:0]    center_reg, axis_reg, corner_reg;

  // line stores and window, [column left..right][row top..bottom]
  logic [PixW-1:0] upper_line [gblur_pkg::MaxWidthDef];
  logic [PixW-1:0] lower_line [gblur_pkg::MaxWidthDef];
  logic [PixW-1:0] win [3][3];
  int unsigned     in_col, in_row;
  bit              draining;

  blurred_t    blurred_q [$];
  int unsigned fails;
  string       chan_name [4] = '{"red_out", "green_out", "blue_out", "alpha_out"};

  // weighted 3x3 sum per channel, rounded and saturated
  function automatic void queue_blurred(logic done);
    blurred_t    res;
    logic [63:0] ctr, ax, co, acc;
    res.done = done;
    for (int ch = 0; ch < 4; ch++) begin
      ctr = 64'(win[1][1][ch*ChanW +: ChanW]);
      ax  = 64'(win[0][1][ch*ChanW +: ChanW]) + 64'(win[2][1][ch*ChanW +: ChanW])
          + 64'(win[1][0][ch*ChanW +: ChanW]) + 64'(win[1][2][ch*ChanW +: ChanW]);
      co  = 64'(win[0][0][ch*ChanW +: ChanW]) + 64'(win[2][0][ch*ChanW +: ChanW])
          + 64'(win[0][2][ch*ChanW +: ChanW]) + 64'(win[2][2][ch*ChanW +: ChanW]);
      acc = ctr * 64'(center_reg) + ax * 64'(axis_reg) + co * 64'(corner_reg)
          + (64'd1 << gblur_pkg::RoundBit);
      acc = acc >> gblur_pkg::FracBits;
      if (acc > ChanMax) acc = ChanMax;
      res.pix[ch*ChanW +: ChanW] = acc[ChanW-1:0];
    end
    blurred_q.push_back(res);
  endfunction

  function automatic void slide_window();
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
  endfunction

  // new column enters on the right; the first column fills the whole window
  function automatic void run_column(logic [PixW-1:0] top, logic [PixW-1:0] mid,
                                     logic [PixW-1:0] bot, int unsigned col,
                                     int unsigned cols, logic last_row);
    if (col != 0) slide_window();
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = bot;
    if (col == 0) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] = win[2][r];
        win[1][r] = win[2][r];
      end
    end
    if (col >= 1) queue_blurred(1'b0);
    // right edge: repeat the last column
    if (col >= cols - 1) begin
      slide_window();
      queue_blurred(last_row);
    end
  endfunction

  function automatic void predict_item(logic kind, logic [PixW-1:0] pix);
    int unsigned     cols, rows, col;
    logic [ColW-1:0] idx;
    logic [PixW-1:0] top, mid;
    bit              end_line;
    cols = (width_reg == '0) ? 1 :
           ((32'(width_reg) > gblur_pkg::MaxWidthDef) ? gblur_pkg::MaxWidthDef
                                                      : 32'(width_reg));
    rows = (height_reg == '0) ? 1 :
           ((32'(height_reg) > gblur_pkg::MaxHeight) ? gblur_pkg::MaxHeight
                                                     : 32'(height_reg));
    col  = (in_col >= gblur_pkg::MaxWidthDef) ? gblur_pkg::MaxWidthDef - 1 : in_col;
    idx  = ColW'(col);
    end_line = col >= cols - 1;
    if (kind != KindFlush) begin
      // pixels are dropped while the last row drains
      if (draining) return;
      if (in_row == 0) begin
        upper_line[idx] = pix;
        lower_line[idx] = pix;
      end else begin
        top = upper_line[idx];
        mid = lower_line[idx];
        upper_line[idx] = mid;
        lower_line[idx] = pix;
        run_column(top, mid, pix, col, cols, 1'b0);
      end
      if (end_line) begin
        in_col = 0;
        in_row++;
        if (in_row >= rows) draining = 1'b1;
      end else begin
        in_col = col + 1;
      end
    end else begin
      // flush only counts while draining; bottom row repeats the middle one
      if (!draining) return;
      top = upper_line[idx];
      mid = lower_line[idx];
      run_column(top, mid, mid, col, cols, 1'b1);
      if (end_line) begin
        in_col   = 0;
        in_row   = 0;
        draining = 1'b0;
      end else begin
        in_col = col + 1;
      end
    end
  endfunction

  // watch register port and both streams
  always @(posedge clk_i or negedge rst_ni) begin
    blurred_t want;
    if (!rst_ni) begin
      width_reg  = gblur_pkg::WidthRst;
      height_reg = gblur_pkg::HeightRst;
      center_reg = gblur_pkg::CenterRst;
      axis_reg   = gblur_pkg::AxisRst;
      corner_reg = gblur_pkg::CornerRst;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) win[c][r] = '0;
      end
      in_col   = 0;
      in_row   = 0;
      draining = 1'b0;
      blurred_q.delete();
      fails = 0;
      fail_count_o <= 0;
      awaiting_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gblur_pkg::REG_WIDTH:  width_reg  = cfg_data_i[gblur_pkg::ImgWidthW-1:0];
          gblur_pkg::REG_HEIGHT: height_reg = cfg_data_i[gblur_pkg::ImgHeightW-1:0];
          gblur_pkg::REG_CENTER: center_reg = cfg_data_i[gblur_pkg::WeightW-1:0];
          gblur_pkg::REG_AXIS:   axis_reg   = cfg_data_i[gblur_pkg::WeightW-1:0];
          gblur_pkg::REG_CORNER: corner_reg = cfg_data_i[gblur_pkg::WeightW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) predict_item(s_user_i, s_data_i);
      if (m_valid_i && m_ready_i) begin
        if (blurred_q.size() == 0) begin
          $error("result with nothing expected: tdata %h tlast %b", m_data_i, m_last_i);
          fails++;
        end else begin
          want = blurred_q.pop_front();
          for (int ch = 0; ch < 4; ch++) begin
            if (m_data_i[ch*ChanW +: ChanW] !== want.pix[ch*ChanW +: ChanW]) begin
              $error("%s: expected %0d, actual %0d", chan_name[ch],
                     want.pix[ch*ChanW +: ChanW], m_data_i[ch*ChanW +: ChanW]);
              fails++;
            end
          end
          if (m_last_i !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, m_last_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      awaiting_o   <= blurred_q.size();
    end
  end

endmodule

// ===== verif/tb_gaussian_blur_3x3_rgba.sv =====
`timescale 1ns / 1ps
// top of the 3x3 gaussian blur testbench: clock, reset, register setup and
// pixel frames with random stalls; checking is done in gblur_checker
// depends on gblur_pkg, gblur_checker and the blur rtl
module tb_gaussian_blur_3x3_rgba;

  localparam int unsigned ChanW       = gblur_pkg::ChannelBitsDef;
  localparam int unsigned PixW        = 4 * ChanW;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned CycleLimit  = 1000000;
  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [PixW-1:0]                s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [PixW-1:0]                m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_we_i      = 1'b0;
  logic [gblur_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [gblur_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned fail_count, awaiting;
  int unsigned src_idle_pct  = 20;
  int unsigned sink_idle_pct = 57;
  int unsigned cycle_count   = 0;

  gaussian_blur_3x3_rgba u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  gblur_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  always #2 clk_i = ~clk_i;

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL gaussian_blur_3x3_rgba");
      $finish;
    end
  end

  // channels are all zero, all ones or random
  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] p;
    for (int ch = 0; ch < 4; ch++) begin
      case ($urandom_range(3))
        0:       p[ch*ChanW +: ChanW] = '0;
        1:       p[ch*ChanW +: ChanW] = '1;
        default: p[ch*ChanW +: ChanW] = ChanW'($urandom_range(65535));
      endcase
    end
    return p;
  endfunction

  function automatic logic [gblur_pkg::WeightW-1:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return '1;
    if (pick < 35) return gblur_pkg::WeightW'($urandom_range(65535));
    return gblur_pkg::WeightW'($urandom_range(12000));
  endfunction

  // one item, with random sender gaps; returns at the edge that takes it
  task automatic offer_item(logic kind, logic [PixW-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold off until every expected result is out and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [gblur_pkg::CfgDataW-1:0] cols,
                           logic [gblur_pkg::CfgDataW-1:0] rows,
                           logic [gblur_pkg::CfgDataW-1:0] center,
                           logic [gblur_pkg::CfgDataW-1:0] axis,
                           logic [gblur_pkg::CfgDataW-1:0] corner);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gblur_pkg::REG_WIDTH;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= gblur_pkg::REG_HEIGHT;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= gblur_pkg::REG_CENTER;
    cfg_data_i <= center;
    @(posedge clk_i);
    cfg_idx_i  <= gblur_pkg::REG_AXIS;
    cfg_data_i <= axis;
    @(posedge clk_i);
    cfg_idx_i  <= gblur_pkg::REG_CORNER;
    cfg_data_i <= corner;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // whole frame; noise puts a dropped item ahead of some real ones
  task automatic run_frame(int unsigned cols, int unsigned rows, int unsigned noise_pct);
    for (int unsigned i = 0; i < cols * rows; i++) begin
      if ($urandom_range(99) < noise_pct) offer_item(KindFlush, rand_pixel());
      offer_item(KindPixel, rand_pixel());
    end
    for (int unsigned i = 0; i < cols; i++) begin
      if ($urandom_range(99) < noise_pct) offer_item(KindPixel, rand_pixel());
      offer_item(KindFlush, rand_pixel());
    end
  endtask

  initial begin
    int unsigned                    item_total, cols, rows;
    logic [gblur_pkg::CfgDataW-1:0] cols_val, rows_val;
    bit                             first_frame;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small frame, full weights so sums can saturate
    load_regs(16'd3, 16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // flush with no frame in progress is dropped
    offer_item(KindFlush, '1);
    for (int i = 0; i < 6; i++) begin
      offer_item(KindPixel, (i == 0) ? '1 : ((i == 1) ? '0 : rand_pixel()));
      // flush in the middle of a line is dropped
      if (i == 0) offer_item(KindFlush, rand_pixel());
    end
    offer_item(KindFlush, rand_pixel());
    // pixel while draining is dropped
    offer_item(KindPixel, '1);
    offer_item(KindFlush, rand_pixel());
    offer_item(KindFlush, rand_pixel());
    settle();

    // zero size acts as one pixel, zero weights
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    offer_item(KindPixel, '1);
    offer_item(KindFlush, '0);
    settle();

    // line shortened mid-line and frame cut short mid-frame
    load_regs(16'd4, 16'hFFFF, gblur_pkg::CenterRst, gblur_pkg::AxisRst,
              gblur_pkg::CornerRst);
    for (int i = 0; i < 6; i++) offer_item(KindPixel, rand_pixel());
    settle();
    load_regs(16'd2, 16'd3, gblur_pkg::CenterRst, gblur_pkg::AxisRst,
              gblur_pkg::CornerRst);
    for (int i = 0; i < 3; i++) offer_item(KindPixel, rand_pixel());
    offer_item(KindFlush, rand_pixel());
    offer_item(KindFlush, rand_pixel());
    settle();

    // random frames, mostly small
    item_total  = 0;
    first_frame = 1'b1;
    while (item_total < RandomItems) begin
      if (item_total >= 2 * RandomItems / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (item_total >= RandomItems / 3) begin
        src_idle_pct  = 57;
        sink_idle_pct = 20;
      end
      if (first_frame || $urandom_range(99) < 40) begin
        case ($urandom_range(19))
          0:       cols = $urandom_range(49, 200);
          1, 2, 3: cols = $urandom_range(9, 48);
          default: cols = $urandom_range(1, 8);
        endcase
        rows = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        cols_val = (cols == 1 && $urandom_range(1) == 1) ? 16'd0
                                                          : gblur_pkg::CfgDataW'(cols);
        rows_val = (rows == 1 && $urandom_range(1) == 1) ? 16'd0
                                                          : gblur_pkg::CfgDataW'(rows);
        settle();
        load_regs(cols_val, rows_val, rand_weight(), rand_weight(), rand_weight());
        first_frame = 1'b0;
      end
      run_frame(cols, rows, 4);
      item_total += cols * rows + cols;
    end

    settle();
    if (fail_count == 0 && awaiting == 0) begin
      $display("PASS gaussian_blur_3x3_rgba");
    end else begin
      $display("FAIL gaussian_blur_3x3_rgba");
    end
    $finish;
  end

endmodule
